// ===== rtl/dpid_pkg.sv =====
// Shared widths, constants and register indexes of the deadband PID selector.
package dpid_pkg;

  localparam int ERR_W    = 17;
  localparam int ACC_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int MUL_A_W  = 30;
  localparam int MUL_B_W  = 16;
  localparam int MUL_M_W  = MUL_A_W - 1 + MUL_B_W;
  localparam int DIV_N_W  = 32;
  localparam int SUM_W    = 48;
  localparam int REG_IDX_W = 3;

  localparam logic [MUL_B_W-1:0] DECAY_Q16 = 16'd55706;
  localparam int MS_PER_S = 1000;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_TARGET_TEMP   = 3'd0;
  localparam reg_idx_t REG_DEAD_BAND     = 3'd1;
  localparam reg_idx_t REG_GAIN_P        = 3'd2;
  localparam reg_idx_t REG_GAIN_I        = 3'd3;
  localparam reg_idx_t REG_GAIN_D        = 3'd4;
  localparam reg_idx_t REG_DRIVE_FLOOR   = 3'd5;
  localparam reg_idx_t REG_DRIVE_CEILING = 3'd6;
  localparam reg_idx_t REG_ACCUM_LIMIT   = 3'd7;

endpackage

// ===== rtl/dpid_mul.sv =====
// Bit-serial signed-by-unsigned multiplier: one bit of the unsigned operand per cycle.
module dpid_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [dpid_pkg::MUL_A_W-1:0] a,
  input  logic        [dpid_pkg::MUL_B_W-1:0] b,
  output logic                                done,
  output logic        [dpid_pkg::MUL_M_W-1:0] mag,
  output logic                                neg
);

  localparam int AM_W  = dpid_pkg::MUL_A_W - 1;
  localparam int B_W   = dpid_pkg::MUL_B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [AM_W-1:0]  am_r, am_nxt;
  logic [AM_W-1:0]  hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic signed [dpid_pkg::MUL_A_W-1:0] a_neg;
  logic [AM_W:0]    add;

  assign a_neg = -a;
  assign add   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, am_r} : {(AM_W + 1){1'b0}});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    am_nxt   = am_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(B_W);
      neg_nxt  = a[dpid_pkg::MUL_A_W-1];
      am_nxt   = a[dpid_pkg::MUL_A_W-1] ? a_neg[AM_W-1:0] : a[AM_W-1:0];
      hi_nxt   = '0;
      lo_nxt   = b;
    end else if (busy_r) begin
      // Add the multiplicand under the current bit, then shift the pair right.
      hi_nxt  = add[AM_W:1];
      lo_nxt  = {add[0], lo_r[B_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    am_r  <= am_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
  end

  assign done = done_r;
  assign mag  = {hi_r, lo_r};
  assign neg  = neg_r;

endmodule

// ===== rtl/dpid_div.sv =====
// Restoring unsigned divider: one quotient bit per cycle.
module dpid_div #(
  parameter int D_W = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dpid_pkg::DIV_N_W-1:0] num,
  input  logic [D_W-1:0]               den,
  output logic                         done,
  output logic [dpid_pkg::DIV_N_W-1:0] quo
);

  localparam int N_W   = dpid_pkg::DIV_N_W;
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dv_r, dv_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W:0]     shifted;
  logic [D_W:0]     diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[N_W-1]};
  assign diff    = shifted - {1'b0, dv_r};
  assign ge      = !diff[D_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      rem_nxt  = '0;
      dv_nxt   = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
      quo_nxt = {quo_r[N_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/deadband_pid_heat_cool_select_unit.sv =====
// Top level of the deadband PID heat/cool selector.
// One word is taken at a time. A word whose error lies inside the deadband needs only
// the integral decay product; any other word runs through the derivative and integral
// products and quotients and the P, D and I products, with one more product when the
// trial integral is rejected and the output is recomputed with the old one. The work
// is done by the bit-serial multiplier (up to six products) and the restoring divider
// (two quotients), which the sequencer uses one after the other. A finished result
// waits in the output register while the next word is accepted.
module deadband_pid_heat_cool_select_unit #(
  parameter int DT_MIN_MS = 200,
  parameter int DT_MAX_MS = 5000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_temp,
  input  logic [31:0]        in_stamp_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive_value,
  output logic               out_heater_enable,
  output logic               out_fan_enable,
  output logic               out_in_band
);

  localparam int ERR_W   = dpid_pkg::ERR_W;
  localparam int ACC_W   = dpid_pkg::ACC_W;
  localparam int SUM_W   = dpid_pkg::SUM_W;
  localparam int A_W     = dpid_pkg::MUL_A_W;
  localparam int B_W     = dpid_pkg::MUL_B_W;
  localparam int DT_W    = $clog2(DT_MAX_MS + 1);
  localparam int STEP_W  = ACC_W + 2;

  localparam logic [31:0]     DT_MIN_V   = 32'(DT_MIN_MS);
  localparam logic [31:0]     DT_MAX_V   = 32'(DT_MAX_MS);
  localparam logic [DT_W-1:0] DT_FIRST   = DT_W'(dpid_pkg::MS_PER_S);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DECAY = 4'd1;
  localparam logic [3:0] ST_DMUL  = 4'd2;
  localparam logic [3:0] ST_DDIV  = 4'd3;
  localparam logic [3:0] ST_IMUL  = 4'd4;
  localparam logic [3:0] ST_IDIV  = 4'd5;
  localparam logic [3:0] ST_PMUL  = 4'd6;
  localparam logic [3:0] ST_GMUL  = 4'd7;
  localparam logic [3:0] ST_TMUL  = 4'd8;
  localparam logic [3:0] ST_AMUL  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Configuration registers.
  logic [13:0]        target_r;
  logic [10:0]        band_r;
  logic [15:0]        gp_r, gi_r, gd_r;
  logic signed [15:0] floor_r;
  logic [14:0]        ceil_r;
  logic [22:0]        limit_r;

  // Controller state and sequencer.
  logic [3:0]              st_r, st_nxt;
  logic signed [ACC_W-1:0] accum_r, accum_nxt;
  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic [31:0]             last_stamp_r, last_stamp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    mul_go_r, mul_go_nxt;
  logic                    div_go_r, div_go_nxt;

  // Working payload.
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [DT_W-1:0]         dt_r, dt_nxt;
  logic signed [A_W-1:0]   deriv_r, deriv_nxt;
  logic signed [ACC_W-1:0] trial_r, trial_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [A_W-1:0]   mul_a_r, mul_a_nxt;
  logic [B_W-1:0]          mul_b_r, mul_b_nxt;
  logic [31:0]             div_n_r, div_n_nxt;
  logic [DT_W-1:0]         div_d_r, div_d_nxt;
  logic signed [15:0]      res_drive_r, res_drive_nxt;
  logic                    res_band_r, res_band_nxt;
  logic signed [15:0]      out_drive_r, out_drive_nxt;
  logic                    out_heat_r, out_heat_nxt;
  logic                    out_fan_r, out_fan_nxt;
  logic                    out_band_r, out_band_nxt;

  logic                         mul_done, mul_neg;
  logic [dpid_pkg::MUL_M_W-1:0] mul_mag;
  logic                         div_done;
  logic [31:0]                  div_q;

  logic                    wr_en;
  logic [2:0]              wr_idx;
  logic signed [ERR_W-1:0] err_in;
  logic signed [ERR_W:0]   err_ext, band_ext, err_diff;
  logic                    in_band_c;
  logic [31:0]             stamp_diff;
  logic [DT_W-1:0]         dt_sel;
  logic signed [SUM_W-1:0] prod_s, pid_tot, raw_c, floor_ext, ceil_ext;
  logic                    keep_c;
  logic signed [15:0]      drive_c;
  logic [ACC_W-1:0]        decay_q;
  logic [A_W-1:0]          deriv_q;
  logic signed [STEP_W-1:0] step_mag, step_s, trial_sum, lim_s;

  dpid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .mag   (mul_mag),
    .neg   (mul_neg)
  );

  dpid_div #(
    .D_W (DT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_n_r),
    .den   (div_d_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_comb begin
    unique case (wr_idx)
      dpid_pkg::REG_TARGET_TEMP:   prdata = 32'(target_r);
      dpid_pkg::REG_DEAD_BAND:     prdata = 32'(band_r);
      dpid_pkg::REG_GAIN_P:        prdata = 32'(gp_r);
      dpid_pkg::REG_GAIN_I:        prdata = 32'(gi_r);
      dpid_pkg::REG_GAIN_D:        prdata = 32'(gd_r);
      dpid_pkg::REG_DRIVE_FLOOR:   prdata = 32'($unsigned(floor_r));
      dpid_pkg::REG_DRIVE_CEILING: prdata = 32'(ceil_r);
      dpid_pkg::REG_ACCUM_LIMIT:   prdata = 32'(limit_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 14'd6656;
      band_r   <= 11'd128;
      gp_r     <= 16'd5120;
      gi_r     <= 16'd102;
      gd_r     <= 16'd1536;
      floor_r  <= -16'sd25600;
      ceil_r   <= 15'd25600;
      limit_r  <= 23'd15360;
    end else if (wr_en) begin
      unique case (wr_idx)
        dpid_pkg::REG_TARGET_TEMP:   target_r <= pwdata[13:0];
        dpid_pkg::REG_DEAD_BAND:     band_r   <= pwdata[10:0];
        dpid_pkg::REG_GAIN_P:        gp_r     <= pwdata[15:0];
        dpid_pkg::REG_GAIN_I:        gi_r     <= pwdata[15:0];
        dpid_pkg::REG_GAIN_D:        gd_r     <= pwdata[15:0];
        dpid_pkg::REG_DRIVE_FLOOR:   floor_r  <= $signed(pwdata[15:0]);
        dpid_pkg::REG_DRIVE_CEILING: ceil_r   <= pwdata[14:0];
        dpid_pkg::REG_ACCUM_LIMIT:   limit_r  <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Input side arithmetic.
  assign err_in    = $signed({3'b000, target_r}) - $signed({in_sample_temp[15], in_sample_temp});
  assign err_ext   = {err_in[ERR_W-1], err_in};
  assign band_ext  = $signed({7'b0000000, band_r});
  assign in_band_c = (err_ext > -band_ext) && (err_ext < band_ext);
  assign err_diff  = err_ext - {last_err_r[ERR_W-1], last_err_r};
  assign stamp_diff = in_stamp_ms - last_stamp_r;

  always_comb begin
    if (last_stamp_r == 32'd0) begin
      dt_sel = DT_FIRST;
    end else if (stamp_diff < DT_MIN_V) begin
      dt_sel = DT_MIN_V[DT_W-1:0];
    end else if (stamp_diff > DT_MAX_V) begin
      dt_sel = DT_MAX_V[DT_W-1:0];
    end else begin
      dt_sel = stamp_diff[DT_W-1:0];
    end
  end

  // Product accumulation and output clamp.
  assign prod_s    = mul_neg ? -$signed(SUM_W'(mul_mag)) : $signed(SUM_W'(mul_mag));
  assign pid_tot   = sum_r + prod_s;
  assign raw_c     = pid_tot >>> 8;
  assign floor_ext = SUM_W'(floor_r);
  assign ceil_ext  = $signed(SUM_W'(ceil_r));
  assign keep_c    = ((raw_c < ceil_ext) || err_r[ERR_W-1]) &&
                     ((raw_c > floor_ext) || (!err_r[ERR_W-1] && (err_r != '0)));

  always_comb begin
    if (raw_c < floor_ext) begin
      drive_c = floor_r;
    end else if (raw_c > ceil_ext) begin
      drive_c = $signed({1'b0, ceil_r});
    end else begin
      drive_c = raw_c[15:0];
    end
  end

  // Quotients and scaled magnitudes carry the sign of the product that fed them.
  assign decay_q   = mul_mag[ACC_W+15:16];
  assign deriv_q   = div_q[A_W-1:0];
  assign step_mag  = $signed({3'b000, div_q[ACC_W-2:0]});
  assign step_s    = mul_neg ? -step_mag : step_mag;
  assign trial_sum = STEP_W'(accum_r) + step_s;
  assign lim_s     = $signed({3'b000, limit_r});

  always_comb begin
    st_nxt         = st_r;
    accum_nxt      = accum_r;
    last_err_nxt   = last_err_r;
    last_stamp_nxt = last_stamp_r;
    out_valid_nxt  = out_valid_r;
    mul_go_nxt     = 1'b0;
    div_go_nxt     = 1'b0;
    err_nxt        = err_r;
    dt_nxt         = dt_r;
    deriv_nxt      = deriv_r;
    trial_nxt      = trial_r;
    sum_nxt        = sum_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    div_n_nxt      = div_n_r;
    div_d_nxt      = div_d_r;
    res_drive_nxt  = res_drive_r;
    res_band_nxt   = res_band_r;
    out_drive_nxt  = out_drive_r;
    out_heat_nxt   = out_heat_r;
    out_fan_nxt    = out_fan_r;
    out_band_nxt   = out_band_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          err_nxt        = err_in;
          dt_nxt         = dt_sel;
          last_stamp_nxt = in_stamp_ms;
          mul_go_nxt     = 1'b1;
          if (in_band_c) begin
            mul_a_nxt = A_W'(accum_r);
            mul_b_nxt = dpid_pkg::DECAY_Q16;
            st_nxt    = ST_DECAY;
          end else begin
            mul_a_nxt = A_W'(err_diff);
            mul_b_nxt = B_W'(dpid_pkg::MS_PER_S);
            st_nxt    = ST_DMUL;
          end
        end
      end
      ST_DECAY: begin
        if (mul_done) begin
          accum_nxt     = mul_neg ? -$signed(decay_q) : $signed(decay_q);
          last_err_nxt  = err_r;
          res_drive_nxt = '0;
          res_band_nxt  = 1'b1;
          st_nxt        = ST_OUT;
        end
      end
      ST_DMUL: begin
        if (mul_done) begin
          div_n_nxt  = mul_mag[31:0];
          div_d_nxt  = dt_r;
          div_go_nxt = 1'b1;
          st_nxt     = ST_DDIV;
        end
      end
      ST_DDIV: begin
        if (div_done) begin
          deriv_nxt  = mul_neg ? -$signed(deriv_q) : $signed(deriv_q);
          mul_a_nxt  = A_W'(err_r);
          mul_b_nxt  = B_W'(dt_r);
          mul_go_nxt = 1'b1;
          st_nxt     = ST_IMUL;
        end
      end
      ST_IMUL: begin
        if (mul_done) begin
          div_n_nxt  = mul_mag[31:0];
          div_d_nxt  = DT_W'(dpid_pkg::MS_PER_S);
          div_go_nxt = 1'b1;
          st_nxt     = ST_IDIV;
        end
      end
      ST_IDIV: begin
        if (div_done) begin
          if (trial_sum < -lim_s) begin
            trial_nxt = ACC_W'(-lim_s);
          end else if (trial_sum > lim_s) begin
            trial_nxt = ACC_W'(lim_s);
          end else begin
            trial_nxt = trial_sum[ACC_W-1:0];
          end
          mul_a_nxt  = A_W'(err_r);
          mul_b_nxt  = gp_r;
          mul_go_nxt = 1'b1;
          st_nxt     = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (mul_done) begin
          sum_nxt    = prod_s;
          mul_a_nxt  = deriv_r;
          mul_b_nxt  = gd_r;
          mul_go_nxt = 1'b1;
          st_nxt     = ST_GMUL;
        end
      end
      ST_GMUL: begin
        if (mul_done) begin
          sum_nxt    = pid_tot;
          mul_a_nxt  = A_W'(trial_r);
          mul_b_nxt  = gi_r;
          mul_go_nxt = 1'b1;
          st_nxt     = ST_TMUL;
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          if (keep_c) begin
            // The trial integral does not push further into saturation.
            accum_nxt     = trial_r;
            last_err_nxt  = err_r;
            res_drive_nxt = drive_c;
            res_band_nxt  = 1'b0;
            st_nxt        = ST_OUT;
          end else begin
            mul_a_nxt  = A_W'(accum_r);
            mul_b_nxt  = gi_r;
            mul_go_nxt = 1'b1;
            st_nxt     = ST_AMUL;
          end
        end
      end
      ST_AMUL: begin
        if (mul_done) begin
          last_err_nxt  = err_r;
          res_drive_nxt = drive_c;
          res_band_nxt  = 1'b0;
          st_nxt        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_band_nxt  = res_band_r;
          out_heat_nxt  = !res_band_r && (res_drive_r > 16'sd0);
          out_fan_nxt   = !res_band_r && !(res_drive_r > 16'sd0);
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      accum_r      <= '0;
      last_err_r   <= '0;
      last_stamp_r <= '0;
      out_valid_r  <= 1'b0;
      mul_go_r     <= 1'b0;
      div_go_r     <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      accum_r      <= accum_nxt;
      last_err_r   <= last_err_nxt;
      last_stamp_r <= last_stamp_nxt;
      out_valid_r  <= out_valid_nxt;
      mul_go_r     <= mul_go_nxt;
      div_go_r     <= div_go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    dt_r        <= dt_nxt;
    deriv_r     <= deriv_nxt;
    trial_r     <= trial_nxt;
    sum_r       <= sum_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    div_n_r     <= div_n_nxt;
    div_d_r     <= div_d_nxt;
    res_drive_r <= res_drive_nxt;
    res_band_r  <= res_band_nxt;
    out_drive_r <= out_drive_nxt;
    out_heat_r  <= out_heat_nxt;
    out_fan_r   <= out_fan_nxt;
    out_band_r  <= out_band_nxt;
  end

  assign in_ready          = (st_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_drive_value   = out_drive_r;
  assign out_heater_enable = out_heat_r;
  assign out_fan_enable    = out_fan_r;
  assign out_in_band       = out_band_r;

endmodule
